@@ rtl/core/bud_pkg.sv @@
// types and codes shared by the buddy allocator
`timescale 1ns / 1ps
`default_nettype none
package bud_pkg;
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NULL      = 3'd1,
        ST_TOO_LARGE = 3'd2,
        ST_NO_MEMORY = 3'd3,
        ST_MISALIGN  = 3'd4,
        ST_BOUNDS    = 3'd5,
        ST_NOT_LIVE  = 3'd6,
        ST_DOUBLE    = 3'd7
    } status_t;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic        op;
        logic [15:0] request_bytes;
        logic [15:0] user_offset;
        logic        no_pointer;
    } req_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] granted_offset;
        logic [4:0]  granted_order;
    } rsp_t;
endpackage
`default_nettype wire

@@ rtl/core/bud_req_if.sv @@
// valid/ready channel carrying one allocator request word
`timescale 1ns / 1ps
`default_nettype none
interface bud_req_if;
    import bud_pkg::*;
    logic valid;
    logic ready;
    req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/bud_rsp_if.sv @@
// valid/ready channel carrying one allocator response word
`timescale 1ns / 1ps
`default_nettype none
interface bud_rsp_if;
    import bud_pkg::*;
    logic valid;
    logic ready;
    rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/buddy_allocator.sv @@
// binary buddy allocator: top level with sequencer and granule memories
//
// Usage: one request word enters on req (op, request_bytes, user_offset,
// no_pointer); exactly one response word (status, granted_offset,
// granted_order) leaves on rsp for each request. Requests are handled one
// at a time: req.ready is high only while the sequencer is idle.
// An allocate finds the smallest order that fits, scans up for a non-empty
// list, pops its head and splits it down to that order. A free checks the
// pointer, then the block, then merges with each free buddy, walking that
// order's list to unlink it, and lists the result.
// The granule memories (link, order and marks) have registered read data.
// A response waits in an output register while rsp.ready is low; the next
// request is accepted only after the response has been taken.
// Reset: the list heads reset to "top block free", then a clearing pass over
// all 2^(MAX_ORDER_LOG - MIN_ORDER_LOG) granules (2048 by default) writes each
// granule's order, marks and link (nil); req.ready stays low until it ends.
`timescale 1ns / 1ps
`default_nettype none
module buddy_allocator #(
    parameter int MIN_ORDER_LOG = 5,
    parameter int MAX_ORDER_LOG = 16,
    parameter int HEADER_BYTES  = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    bud_req_if.sink   req,
    bud_rsp_if.source rsp
);
    import bud_pkg::*;

    localparam int GW = MAX_ORDER_LOG - MIN_ORDER_LOG;      // granule index bits
    localparam int NUM_ORD = GW + 1;
    localparam int NUM_GRAN = 1 << GW;
    localparam int KW = $clog2(NUM_ORD + 1);
    localparam int PW = GW + 1;                             // granule incl. nil
    localparam int AW = MAX_ORDER_LOG + 2;                  // wide address math
    localparam logic [PW-1:0] NIL = PW'(NUM_GRAN);
    localparam logic [KW-1:0] TOPK = KW'(NUM_ORD - 1);
    // reciprocal of the header size for the alignment check
    localparam int RS = 24;
    localparam int PRW = RS + 16;
    localparam logic [RS-1:0] HRCP =
        RS'(((64'd1 << RS) + 64'(HEADER_BYTES) - 64'd1) / 64'(HEADER_BYTES));

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_A_ORD, S_A_SCAN, S_A_RD, S_A_POP, S_A_SPLIT, S_A_DONE,
        S_F_RD, S_F_CHK, S_F_BRD, S_F_BCHK, S_F_WALK, S_F_WRD, S_F_MERGE,
        S_F_PUSH, S_RESP
    } state_t;

    state_t state_reg;
    logic [PW-1:0] heads_reg [NUM_ORD];
    logic [GW-1:0] clr_reg;

    // granule memories: link, order, free mark, start mark
    logic [PW-1:0] next_mem [NUM_GRAN];
    logic [4:0]    ord_mem  [NUM_GRAN];
    logic          free_mem [NUM_GRAN];
    logic          start_mem[NUM_GRAN];

    logic [GW-1:0] rd_addr;
    logic [PW-1:0] next_q;
    logic [4:0]    ord_q;
    logic          free_q, start_q;

    req_t    in_reg;
    rsp_t    out_reg;
    logic    out_valid_reg;
    logic [KW-1:0] k_reg, t_reg;
    logic [PW-1:0] g_reg, b_reg, cur_reg, prev_reg;
    logic [AW-1:0] need_reg;

    // write ports: link memory, order/mark memories and list heads
    logic          we_link, we_meta;
    logic [GW-1:0] wa_link, wa_meta;
    logic [PW-1:0] wd_link;
    logic [4:0]    wd_ord;
    logic          wd_free, wd_start;
    logic          we_head;
    logic [KW-1:0] wh_k;
    logic [PW-1:0] wh_v;

    always_ff @(posedge clk)
    begin
        if (we_link)
        begin
            next_mem[wa_link] <= wd_link;
        end
        if (we_meta)
        begin
            ord_mem[wa_meta]   <= wd_ord;
            free_mem[wa_meta]  <= wd_free;
            start_mem[wa_meta] <= wd_start;
        end
        next_q  <= next_mem[rd_addr];
        ord_q   <= ord_mem[rd_addr];
        free_q  <= free_mem[rd_addr];
        start_q <= start_mem[rd_addr];
    end

    logic [PW-1:0] head_k;
    logic [AW-1:0] uoff_w, baddr_w, halfsz;
    logic [PRW-1:0] hprod_w;
    logic [AW-1:0] hquo_w, hrem_w;
    logic [PW-1:0] bsplit, bbuddy;
    logic [4:0]    k_ord;
    assign head_k  = heads_reg[k_reg[KW-1:0] < KW'(NUM_ORD) ? k_reg : TOPK];
    assign uoff_w  = AW'(in_reg.user_offset);
    assign baddr_w = uoff_w - AW'(HEADER_BYTES);
    assign hprod_w = PRW'(in_reg.user_offset) * PRW'(HRCP);
    assign hquo_w  = AW'(hprod_w >> RS);
    assign hrem_w  = uoff_w - hquo_w * AW'(HEADER_BYTES);
    assign halfsz  = AW'(1) << (k_reg - KW'(1));
    assign bsplit  = g_reg + PW'(halfsz);
    assign bbuddy  = g_reg ^ (PW'(1) << k_reg);
    assign k_ord   = 5'(k_reg) + 5'(MIN_ORDER_LOG);

    assign req.ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

    always_comb
    begin
        we_link = 1'b0; wa_link = '0; wd_link = '0;
        we_meta = 1'b0; wa_meta = '0; wd_ord = '0; wd_free = 1'b0; wd_start = 1'b0;
        we_head = 1'b0; wh_k = '0; wh_v = '0;
        rd_addr = g_reg[GW-1:0];
        case (state_reg)
            S_CLEAR:
            begin
                // granule 0 starts as the free top block, all others empty
                we_meta = 1'b1; wa_meta = clr_reg;
                wd_ord = (clr_reg == '0) ? 5'(MAX_ORDER_LOG) : 5'd0;
                wd_free = (clr_reg == '0); wd_start = (clr_reg == '0);
                we_link = 1'b1; wa_link = clr_reg; wd_link = NIL;
            end
            S_A_RD:   rd_addr = head_k[GW-1:0];
            S_A_SPLIT:
            begin
                if (k_reg > t_reg)
                begin
                    we_meta = 1'b1; wa_meta = bsplit[GW-1:0];
                    wd_ord = k_ord - 5'd1; wd_free = 1'b1; wd_start = 1'b1;
                    we_link = 1'b1; wa_link = bsplit[GW-1:0];
                    wd_link = heads_reg[k_reg - KW'(1)];
                    we_head = 1'b1; wh_k = k_reg - KW'(1); wh_v = bsplit;
                end
            end
            S_A_DONE:
            begin
                we_meta = 1'b1; wa_meta = g_reg[GW-1:0];
                wd_ord = k_ord; wd_free = 1'b0; wd_start = 1'b1;
            end
            S_F_BRD:  rd_addr = bbuddy[GW-1:0];
            S_F_WRD:  rd_addr = cur_reg[GW-1:0];
            S_F_WALK:
            begin
                rd_addr = cur_reg[GW-1:0];
                if (cur_reg == b_reg)
                begin
                    if (prev_reg == NIL)
                    begin
                        we_head = 1'b1; wh_k = k_reg; wh_v = next_q;
                    end
                    else
                    begin
                        we_link = 1'b1; wa_link = prev_reg[GW-1:0]; wd_link = next_q;
                    end
                end
            end
            S_F_MERGE:
            begin
                we_meta = 1'b1;
                wa_meta = (b_reg > g_reg) ? b_reg[GW-1:0] : g_reg[GW-1:0];
                wd_ord = '0; wd_free = 1'b0; wd_start = 1'b0;
            end
            S_F_PUSH:
            begin
                we_meta = 1'b1; wa_meta = g_reg[GW-1:0];
                wd_ord = k_ord; wd_free = 1'b1; wd_start = 1'b1;
                we_link = 1'b1; wa_link = g_reg[GW-1:0]; wd_link = head_k;
                we_head = 1'b1; wh_k = k_reg; wh_v = g_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            out_valid_reg <= 1'b0;
            clr_reg <= '0;
            for (int i = 0; i < NUM_ORD; i++)
            begin
                heads_reg[i] <= (i == NUM_ORD - 1) ? PW'(0) : NIL;
            end
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (we_head)
            begin
                heads_reg[wh_k] <= wh_v;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + GW'(1);
                    if (clr_reg == '1)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (req.valid && req.ready)
                    begin
                        in_reg <= req.data;
                        need_reg <= AW'(req.data.request_bytes) + AW'(HEADER_BYTES);
                        k_reg <= '0;
                        state_reg <= (req.data.op == OP_ALLOC) ? S_A_ORD : S_F_CHK;
                    end
                end
                S_A_ORD:
                begin
                    if (k_reg > TOPK)
                    begin
                        out_reg <= '{ST_TOO_LARGE, 16'd0, 5'd0};
                        state_reg <= S_RESP;
                    end
                    else if ((AW'(1) << (AW'(k_reg) + AW'(MIN_ORDER_LOG))) >= need_reg)
                    begin
                        t_reg <= k_reg;
                        state_reg <= S_A_SCAN;
                    end
                    else
                    begin
                        k_reg <= k_reg + KW'(1);
                    end
                end
                S_A_SCAN:
                begin
                    if (k_reg > TOPK)
                    begin
                        out_reg <= '{ST_NO_MEMORY, 16'd0, 5'd0};
                        state_reg <= S_RESP;
                    end
                    else if (head_k == NIL)
                    begin
                        k_reg <= k_reg + KW'(1);
                    end
                    else
                    begin
                        g_reg <= head_k;
                        state_reg <= S_A_RD;
                    end
                end
                S_A_RD: state_reg <= S_A_POP;
                S_A_POP:
                begin
                    heads_reg[k_reg] <= next_q;
                    state_reg <= S_A_SPLIT;
                end
                S_A_SPLIT:
                begin
                    if (k_reg > t_reg)
                    begin
                        k_reg <= k_reg - KW'(1);
                    end
                    else
                    begin
                        state_reg <= S_A_DONE;
                    end
                end
                S_A_DONE:
                begin
                    out_reg <= '{ST_OK,
                        16'((AW'(g_reg) << MIN_ORDER_LOG) + AW'(HEADER_BYTES)), k_ord};
                    state_reg <= S_RESP;
                end
                S_F_CHK:
                begin
                    if (in_reg.no_pointer)
                    begin
                        out_reg <= '{ST_NULL, 16'd0, 5'd0};
                        state_reg <= S_RESP;
                    end
                    else if (hrem_w != '0)
                    begin
                        out_reg <= '{ST_MISALIGN, 16'd0, 5'd0};
                        state_reg <= S_RESP;
                    end
                    else if (uoff_w >= (AW'(1) << MAX_ORDER_LOG)
                             || uoff_w < AW'(HEADER_BYTES))
                    begin
                        out_reg <= '{ST_BOUNDS, 16'd0, 5'd0};
                        state_reg <= S_RESP;
                    end
                    else if (baddr_w[MIN_ORDER_LOG-1:0] != '0)
                    begin
                        out_reg <= '{ST_NOT_LIVE, 16'd0, 5'd0};
                        state_reg <= S_RESP;
                    end
                    else
                    begin
                        g_reg <= PW'(baddr_w >> MIN_ORDER_LOG);
                        state_reg <= S_F_RD;
                    end
                end
                S_F_RD:
                begin
                    // read latency: memory output valid next cycle
                    state_reg <= S_F_BCHK;
                    b_reg <= NIL;
                end
                S_F_BCHK:
                begin
                    if (b_reg == NIL)
                    begin
                        // checking the freed block itself
                        if (!start_q || ord_q < 5'(MIN_ORDER_LOG)
                            || ord_q > 5'(MAX_ORDER_LOG))
                        begin
                            out_reg <= '{ST_NOT_LIVE, 16'd0, 5'd0};
                            state_reg <= S_RESP;
                        end
                        else if (free_q)
                        begin
                            out_reg <= '{ST_DOUBLE, 16'd0, 5'd0};
                            state_reg <= S_RESP;
                        end
                        else
                        begin
                            k_reg <= KW'(ord_q - 5'(MIN_ORDER_LOG));
                            state_reg <= S_F_BRD;
                        end
                    end
                    else if (!start_q || !free_q || ord_q != k_ord)
                    begin
                        state_reg <= S_F_PUSH;
                    end
                    else
                    begin
                        cur_reg <= heads_reg[k_reg];
                        prev_reg <= NIL;
                        state_reg <= S_F_WRD;
                    end
                end
                S_F_BRD:
                begin
                    if (k_reg >= TOPK)
                    begin
                        state_reg <= S_F_PUSH;
                    end
                    else
                    begin
                        b_reg <= bbuddy;
                        state_reg <= S_F_BCHK;
                    end
                end
                S_F_WRD:
                begin
                    if (cur_reg == NIL)
                    begin
                        state_reg <= S_F_MERGE;
                    end
                    else
                    begin
                        state_reg <= S_F_WALK;
                    end
                end
                S_F_WALK:
                begin
                    if (cur_reg == b_reg)
                    begin
                        state_reg <= S_F_MERGE;
                    end
                    else
                    begin
                        prev_reg <= cur_reg;
                        cur_reg <= next_q;
                        state_reg <= S_F_WRD;
                    end
                end
                S_F_MERGE:
                begin
                    if (b_reg < g_reg)
                    begin
                        g_reg <= b_reg;
                    end
                    k_reg <= k_reg + KW'(1);
                    state_reg <= S_F_BRD;
                end
                S_F_PUSH:
                begin
                    out_reg <= '{ST_OK,
                        16'((AW'(g_reg) << MIN_ORDER_LOG) + AW'(HEADER_BYTES)), k_ord};
                    state_reg <= S_RESP;
                end
                S_RESP:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // one response per request, never accepting while a response waits; failed requests grant zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !rsp.valid)
        else $error("response present right after accept");
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !req.ready)
        else $error("ready while response pending");
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.data.status != ST_OK) |->
        (rsp.data.granted_offset == 16'd0 && rsp.data.granted_order == 5'd0))
        else $error("failed request carries nonzero grant");
endmodule
`default_nettype wire

@@ test/bud_checker.sv @@
// checker for the buddy allocator: predicts each response word and compares
`timescale 1ns / 1ps
`default_nettype none
module bud_checker #(
    parameter int MIN_ORDER_LOG = 5,
    parameter int MAX_ORDER_LOG = 16,
    parameter int HEADER_BYTES  = 16
) (
    input wire logic clk,
    input wire logic rst_n,
    bud_req_if req,
    bud_rsp_if rsp,
    output int errors,
    output int pending
);
    import bud_pkg::*;

    localparam int NUM_ORD  = MAX_ORDER_LOG - MIN_ORDER_LOG + 1;
    localparam int NUM_GRAN = 1 << (MAX_ORDER_LOG - MIN_ORDER_LOG);
    localparam int NIL      = NUM_GRAN;

    int heads [NUM_ORD];
    int links [NUM_GRAN];
    int orders [NUM_GRAN];
    bit is_free [NUM_GRAN];
    bit is_start [NUM_GRAN];
    rsp_t expected_rsp [$];

    assign pending = expected_rsp.size();

    task automatic heap_reset();
        for (int k = 0; k < NUM_ORD; k++) heads[k] = NIL;
        for (int g = 0; g < NUM_GRAN; g++)
        begin
            links[g] = 0;
            orders[g] = 0;
            is_free[g] = 0;
            is_start[g] = 0;
        end
        heads[NUM_ORD - 1] = 0;
        links[0] = NIL;
        orders[0] = MAX_ORDER_LOG;
        is_free[0] = 1;
        is_start[0] = 1;
    endtask

    function automatic rsp_t reply(status_t st, int off, int ord);
        rsp_t r;
        r.status = st;
        r.granted_offset = off[15:0];
        r.granted_order = ord[4:0];
        return r;
    endfunction

    task automatic drop_from_list(int g, int k);
        int prev;
        int cur;
        prev = NIL;
        cur = heads[k];
        for (int s = 0; s <= NUM_GRAN && cur < NUM_GRAN; s++)
        begin
            if (cur == g)
            begin
                if (prev == NIL) heads[k] = links[cur];
                else links[prev] = links[cur];
                return;
            end
            prev = cur;
            cur = links[cur];
        end
    endtask

    task automatic predict_alloc(int bytes, output rsp_t r);
        longint need;
        int ord;
        int t;
        int k;
        int g;
        int b;
        need = bytes + HEADER_BYTES;
        ord = MIN_ORDER_LOG;
        while (ord <= MAX_ORDER_LOG && (64'd1 << ord) < need) ord++;
        if (ord > MAX_ORDER_LOG)
        begin
            r = reply(ST_TOO_LARGE, 0, 0);
            return;
        end
        t = ord - MIN_ORDER_LOG;
        k = t;
        while (k < NUM_ORD && heads[k] >= NUM_GRAN) k++;
        if (k >= NUM_ORD)
        begin
            r = reply(ST_NO_MEMORY, 0, 0);
            return;
        end
        g = heads[k];
        heads[k] = links[g];
        while (k > t)
        begin
            k--;
            b = g + (1 << k);
            is_free[b] = 1;
            is_start[b] = 1;
            orders[b] = k + MIN_ORDER_LOG;
            links[b] = heads[k];
            heads[k] = b;
        end
        orders[g] = ord;
        is_free[g] = 0;
        r = reply(ST_OK, (g << MIN_ORDER_LOG) + HEADER_BYTES, ord);
    endtask

    task automatic predict_free(int uoff, output rsp_t r);
        int baddr;
        int g;
        int k;
        int b;
        int hi;
        if (uoff % HEADER_BYTES != 0)
        begin
            r = reply(ST_MISALIGN, 0, 0);
            return;
        end
        if (uoff >= (1 << MAX_ORDER_LOG) || uoff < HEADER_BYTES)
        begin
            r = reply(ST_BOUNDS, 0, 0);
            return;
        end
        baddr = uoff - HEADER_BYTES;
        if ((baddr & ((1 << MIN_ORDER_LOG) - 1)) != 0)
        begin
            r = reply(ST_NOT_LIVE, 0, 0);
            return;
        end
        g = baddr >> MIN_ORDER_LOG;
        if (g >= NUM_GRAN || !is_start[g] || orders[g] < MIN_ORDER_LOG
            || orders[g] > MAX_ORDER_LOG)
        begin
            r = reply(ST_NOT_LIVE, 0, 0);
            return;
        end
        if (is_free[g])
        begin
            r = reply(ST_DOUBLE, 0, 0);
            return;
        end
        is_free[g] = 1;
        k = orders[g] - MIN_ORDER_LOG;
        while (k + 1 < NUM_ORD)
        begin
            b = g ^ (1 << k);
            if (b >= NUM_GRAN || !is_start[b] || !is_free[b]
                || orders[b] != k + MIN_ORDER_LOG)
                break;
            drop_from_list(b, k);
            hi = (b > g) ? b : g;
            if (b < g) g = b;
            is_start[hi] = 0;
            is_free[hi] = 0;
            k++;
            orders[g] = k + MIN_ORDER_LOG;
        end
        links[g] = heads[k];
        heads[k] = g;
        r = reply(ST_OK, (g << MIN_ORDER_LOG) + HEADER_BYTES, k + MIN_ORDER_LOG);
    endtask

    task automatic report(string what, rsp_t got, rsp_t want);
        $display("mismatch %s: got st=%0d off=%0d ord=%0d want st=%0d off=%0d ord=%0d",
                 what, got.status, got.granted_offset, got.granted_order,
                 want.status, want.granted_offset, want.granted_order);
        errors++;
    endtask

    initial
    begin
        errors = 0;
        heap_reset();
    end

    always @(posedge clk)
    begin
        rsp_t r;
        rsp_t want;
        if (rst_n)
        begin
            if (req.valid && req.ready)
            begin
                if (req.data.op == OP_ALLOC)
                    predict_alloc(req.data.request_bytes, r);
                else if (req.data.no_pointer)
                    r = reply(ST_NULL, 0, 0);
                else
                    predict_free(req.data.user_offset, r);
                expected_rsp.push_back(r);
            end
            if (rsp.valid && rsp.ready)
            begin
                if (expected_rsp.size() == 0)
                    report("unexpected word", rsp.data, '0);
                else
                begin
                    want = expected_rsp.pop_front();
                    if (rsp.data.status !== want.status)
                        report("status", rsp.data, want);
                    else if (rsp.data.granted_offset !== want.granted_offset)
                        report("offset", rsp.data, want);
                    else if (rsp.data.granted_order !== want.granted_order)
                        report("order", rsp.data, want);
                end
            end
        end
    end
endmodule
`default_nettype wire

@@ test/testbench.sv @@
// top of the buddy allocator test: stimulus, idling and verdict
`timescale 1ns / 1ps
`default_nettype none
module testbench;
    import bud_pkg::*;

    localparam int WATCHDOG = 20000;

    logic clk;
    logic rst_n;
    int errors;
    int pending;
    int idle_cycles;
    logic [15:0] live [$];

    bud_req_if req ();
    bud_rsp_if rsp ();

    buddy_allocator i_dut (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));
    bud_checker i_checker (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp),
                           .errors(errors), .pending(pending));

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // receiver: random stall before each word, with calm stretches
    initial
    begin
        int w;
        rsp.ready = 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
            repeat (w) @(posedge clk);
            rsp.ready <= 1'b1;
            @(posedge clk iff rsp.valid);
            rsp.ready <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // valid stays high after an accept so a zero wait gives back-to-back words
    task automatic send(logic op, logic [15:0] bytes, logic [15:0] uoff, logic nullp);
        int w;
        w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
        if (w != 0)
        begin
            req.valid <= 1'b0;
            repeat (w) @(posedge clk);
        end
        req.valid <= 1'b1;
        req.data <= '{op: op, request_bytes: bytes, user_offset: uoff, no_pointer: nullp};
        @(posedge clk iff req.ready);
    endtask

    // grant tracking is from the stimulus side: remember offsets granted
    task automatic alloc(logic [15:0] bytes);
        send(OP_ALLOC, bytes, 16'($urandom), 1'($urandom));
        req.valid <= 1'b0;
        @(posedge clk iff (rsp.valid && rsp.ready));
        if (rsp.data.status == ST_OK) live.push_back(rsp.data.granted_offset);
    endtask

    task automatic free_live();
        int i;
        logic [15:0] off;
        i = $urandom_range(0, live.size() - 1);
        off = live[i];
        live.delete(i);
        send(OP_FREE, 16'($urandom), off, 1'b0);
    endtask

    initial
    begin
        int pick;
        idle_cycles = 0;
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.data = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, every status
        alloc(16'hFFFF);
        alloc(16'd65520);
        send(OP_FREE, 16'd0, 16'd16, 1'b0);
        alloc(16'd0);
        alloc(16'd16);
        alloc(16'd17);
        alloc(16'd65520);
        send(OP_FREE, 16'hFFFF, 16'hFFFF, 1'b1);
        send(OP_FREE, 16'd0, 16'd7, 1'b0);
        send(OP_FREE, 16'd0, 16'd0, 1'b0);
        send(OP_FREE, 16'd0, 16'hFFF0, 1'b0);
        send(OP_FREE, 16'd0, 16'd32, 1'b0);
        send(OP_FREE, 16'd0, 16'd48, 1'b0);
        while (live.size() > 0)
        begin
            logic [15:0] off;
            off = live[0];
            free_live();
            send(OP_FREE, 16'd0, off, 1'b0);
        end
        for (int n = 0; n < 6; n++) alloc(16'd16 << n);
        send(OP_FREE, 16'd0, 16'hAAA0, 1'b0);
        send(OP_FREE, 16'd0, 16'h5550, 1'b0);

        // random: mostly allocate/free of live blocks, some noise
        for (int n = 0; n < 450; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                alloc(($urandom_range(0, 7) == 0) ? 16'($urandom)
                      : 16'($urandom_range(0, 2000)));
            else if (pick < 85 && live.size() > 0)
                free_live();
            else if (pick < 92)
                send(OP_FREE, 16'($urandom), 16'($urandom), 1'($urandom));
            else
                send(OP_FREE, 16'($urandom), 16'($urandom_range(1, 4095)) << 4, 1'b0);
        end
        req.valid <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end
endmodule
`default_nettype wire

@@ files.f @@
rtl/core/bud_pkg.sv
rtl/core/bud_req_if.sv
rtl/core/bud_rsp_if.sv
rtl/core/buddy_allocator.sv
test/bud_checker.sv
test/testbench.sv
